>>> src/per_source_flood_blocker_defines.svh
// ----------------------------------------------------------------------------
// per_source_flood_blocker_defines
// assertion macros shared by the flood blocker rtl
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_FLOOD_BLOCKER_DEFINES_SVH
`define PER_SOURCE_FLOOD_BLOCKER_DEFINES_SVH

// same-cycle implication on i_clk, disabled in reset
`define PSFB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, disabled in reset
`define PSFB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/psfb_pkg.sv
// ----------------------------------------------------------------------------
// psfb_pkg
// request and result types, opcodes, status codes and register indexes
// ----------------------------------------------------------------------------
package psfb_pkg;

    localparam int KEY_W     = 64;
    localparam int CLS_W     = 3;
    localparam int MULT_W    = 8;
    localparam int TIME_W    = 32;
    localparam int BASE_W    = 16;
    localparam int OUT_HIT_W = 24;
    localparam int OP_W      = 3;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int AMT_W     = BASE_W + 3;
    localparam int LIM_W     = AMT_W + MULT_W;

    localparam logic [AMT_W-1:0] SOUND_FACTOR = AMT_W'(5);
    localparam logic [CLS_W-1:0] SOUND_CLASS_A = 3'd4;
    localparam logic [CLS_W-1:0] SOUND_CLASS_B = 3'd5;
    localparam logic [OUT_HIT_W-1:0] OUT_HIT_MAX = {OUT_HIT_W{1'b1}};

    localparam logic [OP_W-1:0] OP_CHECK = 3'd0;
    localparam logic [OP_W-1:0] OP_BLOCK = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_PURGE = 3'd4;

    localparam logic [ST_W-1:0] ST_UNBLOCKED = 3'd0;
    localparam logic [ST_W-1:0] ST_EXISTING  = 3'd1;
    localparam logic [ST_W-1:0] ST_NEW       = 3'd2;
    localparam logic [ST_W-1:0] ST_EXEMPT    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_DONE      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_KEY = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [CLS_W-1:0]  queue_index;
        logic [KEY_W-1:0]  source_key;
        logic [MULT_W-1:0] multiplier;
        logic [TIME_W-1:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic                 blocked;
        logic [ST_W-1:0]      status;
        logic [OUT_HIT_W-1:0] hit_count;
    } t_res;

endpackage

>>> src/per_source_flood_blocker.sv
// ----------------------------------------------------------------------------
// per_source_flood_blocker
// fixed-window flood limiter keyed by source, table walked one slot a cycle
// ----------------------------------------------------------------------------
// answers: exempt, purge and unknown requests answer straight from idle;
//   check, block and query walk the filled slots to a match and then evaluate it,
//   or answer from the miss state on a miss; a clear walks the filled slots
// throughput: one request at a time, busy stays high until the answer strobe
// the slot ram read port sets the pace; results are a one-cycle strobe, no stall
// reset: synchronous, control and config registers to defaults and fill count to zero at once
`include "per_source_flood_blocker_defines.svh"

module per_source_flood_blocker #(
    parameter int TABLE_ENTRIES = 64,
    parameter int CLASS_COUNT   = 8,
    parameter int HIT_BITS      = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  psfb_pkg::t_req                      i_req,
    output logic                                o_res_valid,
    output psfb_pkg::t_res                      o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psfb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psfb_pkg::KEY_W-1:0]          i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [HIT_BITS-1:0] HIT_MAX = {HIT_BITS{1'b1}};

    typedef struct packed {
        logic [psfb_pkg::KEY_W-1:0]  key;
        logic [psfb_pkg::CLS_W-1:0]  cls;
        logic [HIT_BITS-1:0]         hits;
        logic [psfb_pkg::TIME_W-1:0] stamp;
        logic                        barred;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_MISS,
        S_CLEAR
    } t_state;

    t_state                        r_state, n_state;
    psfb_pkg::t_req                r_req, n_req;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [CNT_W-1:0]              r_fill, n_fill;
    logic [IDX_W-1:0]              r_slot, n_slot;
    t_entry                        r_ent, n_ent;
    logic [psfb_pkg::AMT_W-1:0]    r_amount, n_amount;
    logic [psfb_pkg::LIM_W-1:0]    r_limit, n_limit;
    psfb_pkg::t_res                r_res, n_res;
    logic                          r_res_valid, n_res_valid;
    logic                          r_enable, n_enable;
    logic                          r_global, n_global;
    logic [psfb_pkg::BASE_W-1:0]   r_window, n_window;
    logic [psfb_pkg::BASE_W-1:0]   r_base, n_base;
    logic [psfb_pkg::KEY_W-1:0]    r_own_key, n_own_key;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    t_entry                        ram_wdata;
    logic [ENT_W-1:0]              ram_rdata_raw;
    t_entry                        ram_rdata;

    logic                          cls_bad_in;
    logic                          exempt_in;
    logic                          sound_in;
    logic                          match;
    logic                          last;
    logic [psfb_pkg::TIME_W-1:0]   elapsed;
    logic                          in_win;
    logic [HIT_BITS-1:0]           hits_inc;
    logic                          over;
    logic                          clr_hit;
    logic                          table_full;

    function automatic logic [psfb_pkg::OUT_HIT_W-1:0] f_out_hits(
        input logic [HIT_BITS-1:0] h
    );
        logic [31:0] w;
        w = 32'(h);
        return (w > 32'(psfb_pkg::OUT_HIT_MAX)) ? psfb_pkg::OUT_HIT_MAX
                                                 : w[psfb_pkg::OUT_HIT_W-1:0];
    endfunction

    function automatic psfb_pkg::t_res f_res(
        input logic                           blk,
        input logic [psfb_pkg::ST_W-1:0]      st,
        input logic [psfb_pkg::OUT_HIT_W-1:0] hits
    );
        psfb_pkg::t_res r;
        r.blocked   = blk;
        r.status    = st;
        r.hit_count = hits;
        return r;
    endfunction

    psfb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_entry'(ram_rdata_raw);

    assign cls_bad_in = !r_global &&
        ({1'b0, i_req.queue_index} >= (psfb_pkg::CLS_W + 1)'(CLASS_COUNT));
    assign exempt_in  = !r_enable || (i_req.source_key == '0) ||
                        (i_req.source_key == r_own_key) || cls_bad_in;
    assign sound_in   = !r_global && ((i_req.queue_index == psfb_pkg::SOUND_CLASS_A) ||
                                      (i_req.queue_index == psfb_pkg::SOUND_CLASS_B));

    assign match    = (ram_rdata.key == r_req.source_key) &&
                      (r_global || (ram_rdata.cls == r_req.queue_index));
    assign last     = (CNT_W'(r_idx) + CNT_W'(1)) == r_fill;
    assign elapsed  = r_req.now_seconds - r_ent.stamp;
    assign in_win   = elapsed <= psfb_pkg::TIME_W'(r_window);
    assign hits_inc = (r_ent.hits == HIT_MAX) ? r_ent.hits : r_ent.hits + HIT_BITS'(1);
    assign over     = 32'(hits_inc) > 32'(r_limit);
    assign clr_hit  = r_global ||
                      ((ram_rdata.cls == r_req.queue_index) && !ram_rdata.barred);
    assign table_full = r_fill == CNT_W'(TABLE_ENTRIES);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_slot      = r_slot;
        n_ent       = r_ent;
        n_amount    = r_amount;
        n_limit     = psfb_pkg::LIM_W'(r_amount) * psfb_pkg::LIM_W'(r_req.multiplier);
        n_res       = r_res;
        n_res_valid = 1'b0;
        n_enable    = r_enable;
        n_global    = r_global;
        n_window    = r_window;
        n_base      = r_base;
        n_own_key   = r_own_key;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req    = i_req;
                    n_idx    = '0;
                    n_amount = sound_in ? psfb_pkg::AMT_W'(r_base) * psfb_pkg::SOUND_FACTOR
                                        : psfb_pkg::AMT_W'(r_base);
                    case (i_req.opcode)
                        psfb_pkg::OP_CHECK: begin
                            if (exempt_in) begin
                                n_res       = f_res(1'b0, psfb_pkg::ST_EXEMPT, '0);
                                n_res_valid = 1'b1;
                            end else begin
                                n_state = (r_fill == '0) ? S_MISS : S_SCAN;
                            end
                        end
                        psfb_pkg::OP_BLOCK: begin
                            if (!r_enable || cls_bad_in) begin
                                n_res       = f_res(1'b0, psfb_pkg::ST_DONE, '0);
                                n_res_valid = 1'b1;
                            end else begin
                                n_state = (r_fill == '0) ? S_MISS : S_SCAN;
                            end
                        end
                        psfb_pkg::OP_QUERY: begin
                            if (!r_enable || cls_bad_in) begin
                                n_res       = f_res(1'b0, psfb_pkg::ST_EXEMPT, '0);
                                n_res_valid = 1'b1;
                            end else begin
                                n_state = (r_fill == '0) ? S_MISS : S_SCAN;
                            end
                        end
                        psfb_pkg::OP_CLEAR: begin
                            if (cls_bad_in || (r_fill == '0)) begin
                                n_res       = f_res(1'b0, psfb_pkg::ST_DONE, '0);
                                n_res_valid = 1'b1;
                            end else begin
                                n_state = S_CLEAR;
                            end
                        end
                        psfb_pkg::OP_PURGE: begin
                            n_fill      = '0;
                            n_res       = f_res(1'b0, psfb_pkg::ST_DONE, '0);
                            n_res_valid = 1'b1;
                        end
                        default: begin
                            n_res       = f_res(1'b0, psfb_pkg::ST_DONE, '0);
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_ent   = ram_rdata;
                    n_slot  = r_idx;
                    n_state = S_EVAL;
                end else if (last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_EVAL: begin
                ram_waddr   = r_slot;
                ram_wdata   = r_ent;
                n_state     = S_IDLE;
                n_res_valid = 1'b1;
                case (r_req.opcode)
                    psfb_pkg::OP_CHECK: begin
                        if (r_ent.barred) begin
                            n_res = f_res(1'b1, psfb_pkg::ST_EXISTING, f_out_hits(r_ent.hits));
                        end else if (in_win) begin
                            ram_we           = 1'b1;
                            ram_wdata.hits   = hits_inc;
                            ram_wdata.barred = over;
                            n_res = f_res(over, over ? psfb_pkg::ST_NEW : psfb_pkg::ST_UNBLOCKED,
                                          f_out_hits(hits_inc));
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata.hits  = HIT_BITS'(1);
                            ram_wdata.stamp = r_req.now_seconds;
                            n_res = f_res(1'b0, psfb_pkg::ST_UNBLOCKED,
                                          psfb_pkg::OUT_HIT_W'(1));
                        end
                    end
                    psfb_pkg::OP_BLOCK: begin
                        ram_we           = 1'b1;
                        ram_wdata.barred = 1'b1;
                        n_res = f_res(1'b1, psfb_pkg::ST_DONE, f_out_hits(r_ent.hits));
                    end
                    psfb_pkg::OP_QUERY: begin
                        n_res = f_res(r_ent.barred,
                                      r_ent.barred ? psfb_pkg::ST_EXISTING
                                                   : psfb_pkg::ST_UNBLOCKED,
                                      f_out_hits(r_ent.hits));
                    end
                    default: begin
                        n_res = f_res(1'b0, psfb_pkg::ST_DONE, '0);
                    end
                endcase
            end
            S_MISS: begin
                ram_waddr          = r_fill[IDX_W-1:0];
                ram_wdata.key      = r_req.source_key;
                ram_wdata.cls      = r_req.queue_index;
                ram_wdata.hits     = '0;
                ram_wdata.stamp    = '0;
                ram_wdata.barred   = 1'b0;
                n_state            = S_IDLE;
                n_res_valid        = 1'b1;
                case (r_req.opcode)
                    psfb_pkg::OP_CHECK: begin
                        if (table_full) begin
                            n_res = f_res(1'b0, psfb_pkg::ST_FULL, '0);
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata.hits  = HIT_BITS'(1);
                            ram_wdata.stamp = r_req.now_seconds;
                            n_fill          = r_fill + CNT_W'(1);
                            n_res = f_res(1'b0, psfb_pkg::ST_UNBLOCKED,
                                          psfb_pkg::OUT_HIT_W'(1));
                        end
                    end
                    psfb_pkg::OP_BLOCK: begin
                        if (table_full) begin
                            n_res = f_res(1'b0, psfb_pkg::ST_FULL, '0);
                        end else begin
                            ram_we           = 1'b1;
                            ram_wdata.barred = 1'b1;
                            n_fill           = r_fill + CNT_W'(1);
                            n_res = f_res(1'b1, psfb_pkg::ST_DONE, '0);
                        end
                    end
                    psfb_pkg::OP_QUERY: begin
                        n_res = f_res(1'b0, psfb_pkg::ST_UNBLOCKED, '0);
                    end
                    default: begin
                        n_res = f_res(1'b0, psfb_pkg::ST_DONE, '0);
                    end
                endcase
            end
            S_CLEAR: begin
                if (clr_hit) begin
                    ram_we          = 1'b1;
                    ram_wdata.hits  = '0;
                    ram_wdata.stamp = '0;
                    if (r_global) begin
                        ram_wdata.barred = 1'b0;
                    end
                end
                if (last) begin
                    n_state     = S_IDLE;
                    n_res       = f_res(1'b0, psfb_pkg::ST_DONE, '0);
                    n_res_valid = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psfb_pkg::CFG_ENABLE: begin
                    n_enable = i_cfg_data[0];
                end
                psfb_pkg::CFG_GLOBAL: begin
                    n_global = i_cfg_data[0];
                    n_fill   = '0;
                end
                psfb_pkg::CFG_WINDOW: begin
                    n_window = i_cfg_data[psfb_pkg::BASE_W-1:0];
                end
                psfb_pkg::CFG_BASE: begin
                    n_base = i_cfg_data[psfb_pkg::BASE_W-1:0];
                end
                psfb_pkg::CFG_OWN_KEY: begin
                    n_own_key = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_res_valid <= 1'b0;
            r_enable    <= 1'b1;
            r_global    <= 1'b0;
            r_window    <= psfb_pkg::BASE_W'(10);
            r_base      <= psfb_pkg::BASE_W'(10);
            r_own_key   <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_res_valid <= n_res_valid;
            r_enable    <= n_enable;
            r_global    <= n_global;
            r_window    <= n_window;
            r_base      <= n_base;
            r_own_key   <= n_own_key;
            r_idx       <= n_idx;
            r_req       <= n_req;
            r_slot      <= n_slot;
            r_ent       <= n_ent;
            r_amount    <= n_amount;
            r_limit     <= n_limit;
            r_res       <= n_res;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = !busy && !start;

    `PSFB_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= CNT_W'(TABLE_ENTRIES), "fill beyond table")
    `PSFB_ASSERT_IMP(a_res_idle, o_res_valid, !busy, "result strobe while still busy")
    `PSFB_ASSERT_NXT(a_start_progress, start && !busy, busy || o_res_valid, "request lost")
    `PSFB_ASSERT_IMP(a_write_busy, ram_we, r_state != S_IDLE, "slot write outside a request")
    `PSFB_ASSERT_NXT(a_eval_answers, r_state == S_EVAL, o_res_valid, "eval without answer")

endmodule

>>> src/psfb_ram.sv
// ----------------------------------------------------------------------------
// psfb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module psfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
